/* rtl/ebt_pkg.sv */
package ebt_pkg;

  typedef struct packed {
    logic enc_a;
    logic enc_b;
    logic button_down;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  screen_mode;
    logic [6:0]  set_hours;
    logic [5:0]  set_minutes;
    logic [5:0]  set_seconds;
    logic [28:0] remaining_ms;
    logic        countdown_running;
    logic        alarm_active;
    logic        editing;
    logic [1:0]  edit_field;
    logic [31:0] stopwatch_ms;
    logic        stopwatch_running;
    logic [7:0]  beep_ms;
  } out_item_t;

  typedef struct packed {
    logic up;
    logic down;
  } move_t;

  typedef enum logic [2:0] {
    CfgLongPress  = 3'd0,
    CfgDoublePress = 3'd1,
    CfgDebounce   = 3'd2,
    CfgAccelWin   = 3'd3,
    CfgAccelFact  = 3'd4,
    CfgAlarmRep   = 3'd5
  } cfg_idx_e;

  localparam logic [2:0] ScrTimer     = 3'd1;
  localparam logic [2:0] ScrStopwatch = 3'd2;

  localparam logic [1:0] FieldHours   = 2'd0;
  localparam logic [1:0] FieldMinutes = 2'd1;
  localparam logic [1:0] FieldSeconds = 2'd2;

  localparam logic [7:0] BeepAlarm  = 8'd200;
  localparam logic [7:0] BeepMove   = 8'd15;
  localparam logic [7:0] BeepButton = 8'd120;

endpackage

/* rtl/ebt_quad.sv */
module ebt_quad import ebt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  logic  enc_a_i,
  input  logic  enc_b_i,
  output move_t move_o
);

  logic [3:0]        hist_q, hist_d;
  logic signed [2:0] acc_q, acc_d;
  logic signed [2:0] acc_sum;

  always_comb begin
    hist_d  = {hist_q[1:0], enc_a_i, enc_b_i};
    acc_sum = acc_q;
    if (hist_d == 4'hD || hist_d == 4'h4 || hist_d == 4'h2 || hist_d == 4'hB) begin
      acc_sum = acc_q + 3'sd1;
    end
    if (hist_d == 4'hE || hist_d == 4'h7 || hist_d == 4'h1 || hist_d == 4'h8) begin
      acc_sum = acc_q - 3'sd1;
    end
    move_o.up   = (acc_sum >= 3'sd2);
    move_o.down = (acc_sum <= -3'sd2);
    acc_d       = (move_o.up || move_o.down) ? 3'sd0 : acc_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      acc_q  <= '0;
    end else if (accept_i) begin
      hist_q <= hist_d;
      acc_q  <= acc_d;
    end
  end

endmodule

/* rtl/ebt_core.sv */
module ebt_core import ebt_pkg::*; #(
  parameter int unsigned MaxHours   = 99,
  parameter int unsigned NumScreens = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        button_i,
  input  move_t       move_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output out_item_t   result_o
);

  localparam logic [6:0] HoursMax = 7'(MaxHours);
  localparam logic [3:0] ScrCount = 4'(NumScreens);
  localparam logic [2:0] ScrLast  = 3'(NumScreens - 1);

  logic [15:0] long_q, dbl_q, deb_q, accw_q, rep_q;
  logic [3:0]  fact_q;

  logic [31:0] now_q, last_move_q, end_q, last_beep_q, press_start_q, last_press_q;
  logic [31:0] last_short_q, sw_start_q, sw_el_q;
  logic [31:0] last_move_d, end_d, last_beep_d, press_start_d, last_press_d;
  logic [31:0] last_short_d, sw_start_d, sw_el_d;
  logic [2:0]  mode_q, mode_d;
  logic [6:0]  hours_q, hours_d;
  logic [5:0]  min_q, min_d, sec_q, sec_d;
  logic [28:0] stored_q, stored_d;
  logic        run_q, run_d, alarm_q, alarm_d, edit_q, edit_d, wait_q, wait_d;
  logic [1:0]  field_q, field_d;
  logic        held_q, held_d, swrun_q, swrun_d;
  logic [7:0]  beep;

  function automatic logic [28:0] preset(logic [6:0] h, logic [5:0] m, logic [5:0] s);
    logic [28:0] r;
    r = 29'(h * 29'd3600000) + 29'(m * 29'd60000) + 29'(s * 29'd1000);
    return r;
  endfunction

  function automatic logic is_expired(logic [31:0] e, logic [31:0] n);
    logic [31:0] d;
    d = e - n;
    return (d == 32'd0) || d[31];
  endfunction

  always_comb begin
    logic              fast;
    logic signed [5:0] step;
    logic signed [8:0] sum;
    logic [31:0]       n;
    n = now_q;
    last_move_d = last_move_q; end_d = end_q; last_beep_d = last_beep_q;
    press_start_d = press_start_q; last_press_d = last_press_q;
    last_short_d = last_short_q; sw_start_d = sw_start_q; sw_el_d = sw_el_q;
    mode_d = mode_q; hours_d = hours_q; min_d = min_q; sec_d = sec_q;
    stored_d = stored_q; run_d = run_q; alarm_d = alarm_q; edit_d = edit_q;
    wait_d = wait_q; field_d = field_q; held_d = held_q; swrun_d = swrun_q;
    beep = '0;
    fast = 1'b0; step = '0; sum = '0;

    if (alarm_q && ((n - last_beep_q) > {16'd0, rep_q})) begin
      beep = BeepAlarm;
      last_beep_d = n;
    end

    if (move_i.up || move_i.down) begin
      fast = (n - last_move_q) < {16'd0, accw_q};
      last_move_d = n;
      step = fast ? $signed({2'b00, fact_q}) : 6'sd1;
      if (move_i.down) step = -step;
      if (mode_q == ScrTimer && edit_q && !run_q) begin
        unique case (field_q)
          FieldHours: begin
            sum = $signed({2'b00, hours_q}) + 9'(step);
            hours_d = sum < 0 ? 7'd0 : (sum > $signed({2'b00, HoursMax}) ? HoursMax : 7'(sum));
          end
          FieldMinutes: begin
            sum = $signed({3'b000, min_q}) + 9'(step);
            min_d = sum < 0 ? 6'd0 : (sum > 9'sd59 ? 6'd59 : 6'(sum));
          end
          default: begin
            sum = $signed({3'b000, sec_q}) + 9'(step);
            sec_d = sum < 0 ? 6'd0 : (sum > 9'sd59 ? 6'd59 : 6'(sum));
          end
        endcase
        stored_d = preset(hours_d, min_d, sec_d);
      end else if (move_i.up) begin
        mode_d = ({1'b0, mode_q} + 4'd1 == ScrCount) ? 3'd0 : mode_q + 3'd1;
      end else begin
        mode_d = (mode_q == 3'd0) ? ScrLast : mode_q - 3'd1;
      end
      beep = BeepMove;
    end

    if (button_i && !held_q) begin
      held_d = 1'b1;
      press_start_d = n;
    end

    if (!button_i && held_q) begin
      if ((n - press_start_q) > {16'd0, long_q}) begin
        beep = BeepButton;
        if (mode_d == ScrTimer && !run_d) begin
          edit_d = !edit_d;
          field_d = FieldMinutes;
        end
      end else if ((n - last_press_q) > {16'd0, deb_q}) begin
        if (wait_d && ((n - last_short_q) < {16'd0, dbl_q})) begin
          wait_d = 1'b0;
          if (mode_d == ScrTimer) begin
            run_d = 1'b0;
            alarm_d = 1'b0;
            stored_d = preset(hours_d, min_d, sec_d);
          end
          if (mode_d == ScrStopwatch) begin
            swrun_d = 1'b0;
            sw_el_d = '0;
          end
          beep = BeepButton;
        end else begin
          wait_d = 1'b1;
          last_short_d = n;
          if (mode_d == ScrTimer) begin
            if (alarm_d) begin
              alarm_d = 1'b0;
            end else if (edit_d) begin
              field_d = (field_d == FieldHours) ? FieldMinutes :
                        (field_d == FieldMinutes) ? FieldSeconds : FieldHours;
            end else if (run_d) begin
              stored_d = is_expired(end_q, n) ? 29'd0 : 29'(end_q - n);
              run_d = 1'b0;
            end else begin
              if (stored_d == 29'd0) stored_d = preset(hours_d, min_d, sec_d);
              end_d = n + {3'd0, stored_d};
              run_d = 1'b1;
            end
          end else if (mode_d == ScrStopwatch) begin
            if (swrun_d) begin
              sw_el_d = n - sw_start_q;
              swrun_d = 1'b0;
            end else begin
              swrun_d = 1'b1;
              sw_start_d = n - sw_el_d;
            end
          end
        end
        last_press_d = n;
      end
      held_d = 1'b0;
    end

    if (wait_d && ((n - last_short_d) > {16'd0, dbl_q})) wait_d = 1'b0;
    if (swrun_d) sw_el_d = n - sw_start_d;
    if (run_d && is_expired(end_d, n)) begin
      run_d = 1'b0;
      stored_d = '0;
      alarm_d = 1'b1;
    end

    result_o.screen_mode       = mode_d;
    result_o.set_hours         = hours_d;
    result_o.set_minutes       = min_d;
    result_o.set_seconds       = sec_d;
    result_o.remaining_ms      = run_d ? 29'(end_d - n) : stored_d;
    result_o.countdown_running = run_d;
    result_o.alarm_active      = alarm_d;
    result_o.editing           = edit_d;
    result_o.edit_field        = field_d;
    result_o.stopwatch_ms      = sw_el_d;
    result_o.stopwatch_running = swrun_d;
    result_o.beep_ms           = beep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q <= 16'd600; dbl_q <= 16'd350; deb_q <= 16'd250;
      accw_q <= 16'd80; fact_q <= 4'd5; rep_q <= 16'd1200;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLongPress:   long_q <= cfg_data_i;
        CfgDoublePress: dbl_q  <= cfg_data_i;
        CfgDebounce:    deb_q  <= cfg_data_i;
        CfgAccelWin:    accw_q <= cfg_data_i;
        CfgAccelFact:   fact_q <= cfg_data_i[3:0];
        CfgAlarmRep:    rep_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0; last_move_q <= '0; end_q <= '0; last_beep_q <= '0;
      press_start_q <= '0; last_press_q <= '0; last_short_q <= '0;
      sw_start_q <= '0; sw_el_q <= '0;
      mode_q <= '0; hours_q <= '0; min_q <= 6'd5; sec_q <= '0;
      stored_q <= 29'd300000;
      run_q <= 1'b0; alarm_q <= 1'b0; edit_q <= 1'b0; wait_q <= 1'b0;
      field_q <= FieldMinutes; held_q <= 1'b0; swrun_q <= 1'b0;
    end else if (accept_i) begin
      now_q <= now_q + 32'd1;
      last_move_q <= last_move_d; end_q <= end_d; last_beep_q <= last_beep_d;
      press_start_q <= press_start_d; last_press_q <= last_press_d;
      last_short_q <= last_short_d; sw_start_q <= sw_start_d; sw_el_q <= sw_el_d;
      mode_q <= mode_d; hours_q <= hours_d; min_q <= min_d; sec_q <= sec_d;
      stored_q <= stored_d;
      run_q <= run_d; alarm_q <= alarm_d; edit_q <= edit_d; wait_q <= wait_d;
      field_q <= field_d; held_q <= held_d; swrun_q <= swrun_d;
    end
  end

endmodule

/* rtl/encoder_button_timer_controller.sv */
// Encoder, button and countdown timer controller.
// Each input item is one millisecond tick carrying the encoder line levels and
// the button level; every accepted item yields exactly one result item with the
// screen, countdown preset, remaining time, alarm, edit, stopwatch and beep state.
// Both channels use valid and stall. An item is accepted when in_valid_i is high
// and in_stall_o is low; a result is taken when out_valid_o is high and out_stall_i
// is low.
// The result of an accepted item is registered in out_q, or while the receiver stalls
// in the skid register. Throughput is one item per cycle while in_stall_o is low; the
// state update between the input handshake and the result register is combinational.
// When the receiver stalls, the waiting result holds and one more item is still
// taken into a skid register; in_stall_o rises only while that skid register is full.
// Configuration registers are written through cfg_we_i, cfg_idx_i and cfg_data_i,
// by the user only while the block is idle; the block does not enforce this. Reset
// sets all registers but out_q and skid_q to defaults: screen 0, a five minute preset.
module encoder_button_timer_controller import ebt_pkg::*; #(
  parameter int unsigned MaxHours   = 99,
  parameter int unsigned NumScreens = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic      accept;
  move_t     move;
  out_item_t result;
  out_item_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ebt_quad u_quad (
    .clk_i,
    .rst_ni,
    .accept_i (accept),
    .enc_a_i  (in_data_i.enc_a),
    .enc_b_i  (in_data_i.enc_b),
    .move_o   (move)
  );

  ebt_core #(
    .MaxHours   (MaxHours),
    .NumScreens (NumScreens)
  ) u_core (
    .clk_i,
    .rst_ni,
    .accept_i   (accept),
    .button_i   (in_data_i.button_down),
    .move_i     (move),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q  <= skid_valid_q || accept;
        skid_valid_q <= skid_valid_q && accept;
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= result;
      end
    end
    if (accept && out_valid_q && (out_stall_i || skid_valid_q)) begin
      skid_q <= result;
    end
  end

endmodule
